### rtl/sra_pkg.sv
// shared types and constants for the staging ring allocator
`default_nettype none

package sra_pkg;

    // result status codes
    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_LARGE   = 3'd2;
    localparam logic [2:0] ST_NOSPACE = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_FREED   = 3'd5;

    // command codes carried on the input tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // bit positions in the entry flags
    localparam int unsigned FLAG_WRAPPED = 0;
    localparam int unsigned FLAG_FREED   = 1;

    // register map: index taken from paddr[2]
    localparam logic        REG_RING_CAPACITY = 1'b0;
    localparam logic [31:0] CAPACITY_RESET    = 32'd16777216;

    // region granularity in bytes, a power of two so rounding up is an add and a mask
    localparam int unsigned ALIGNMENT  = 256;
    localparam logic [32:0] ALIGN_MASK = ~33'(ALIGNMENT - 1);

    typedef struct packed {
        logic [31:0] owner;
        logic [31:0] start;
        logic [31:0] length;
        logic [1:0]  flags;
    } entry_t;

    typedef struct packed {
        logic load;
        logic latch_aligned;
        logic alloc_commit;
        logic scan_rd;
        logic scan_next;
        logic mark;
        logic ret_rd;
        logic retire;
        logic free_end;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_more;
        logic match;
        logic count_zero;
        logic oldest_freed;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/sra_ctrl.sv
// controller state machine sequencing allocate and free commands
`default_nettype none

module sra_ctrl
    import sra_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_command,
    input  wire logic    out_free,
    input  wire dp_sts_t sts,
    output logic         in_ready,
    output dp_cmd_t      cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_LATCH    = 10'b00_0000_0010,
        S_COMMIT   = 10'b00_0000_0100,
        S_SCAN_RD  = 10'b00_0000_1000,
        S_SCAN_CHK = 10'b00_0001_0000,
        S_MARK     = 10'b00_0010_0000,
        S_RET_RD   = 10'b00_0100_0000,
        S_RET_CHK  = 10'b00_1000_0000,
        S_FREE_END = 10'b01_0000_0000,
        S_RESULT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_command == CMD_FREE) ? S_SCAN_RD : S_LATCH;
                end
            end
            S_LATCH:
            begin
                cmd.latch_aligned = 1'b1;
                state_next        = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_RESULT;
            end
            S_SCAN_RD:
            begin
                if (sts.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_RET_RD;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.match)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = S_RET_RD;
            end
            S_RET_RD:
            begin
                if (sts.count_zero)
                begin
                    state_next = S_FREE_END;
                end
                else
                begin
                    cmd.ret_rd = 1'b1;
                    state_next = S_RET_CHK;
                end
            end
            S_RET_CHK:
            begin
                if (sts.oldest_freed)
                begin
                    cmd.retire = 1'b1;
                    state_next = S_RET_RD;
                end
                else
                begin
                    state_next = S_FREE_END;
                end
            end
            S_FREE_END:
            begin
                cmd.free_end = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sra_datapath.sv
// datapath: ring pointers, block table memory, alignment rounding
`default_nettype none

module sra_datapath
    import sra_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [31:0] in_task_id,
    input  wire logic [31:0] in_request_size,
    input  wire logic [31:0] ring_capacity,
    output dp_sts_t          sts,
    output logic [2:0]       res_status,
    output logic [31:0]      res_offset,
    output logic [31:0]      used_bytes,
    output logic [CNT_W-1:0] block_count
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_BLOCKS);

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(pos);
        if (sum >= (CNT_W + 1)'(MAX_BLOCKS))
        begin
            sum = sum - (CNT_W + 1)'(MAX_BLOCKS);
        end
        return sum[IDX_W-1:0];
    endfunction

    entry_t mem [MAX_BLOCKS];

    logic [31:0]           owner_reg;
    logic [31:0]           size_reg;
    logic [32:0]           aligned_reg;
    logic [32:0]           aligned_next;
    logic [31:0]           head_reg;
    logic [31:0]           head_next;
    logic [31:0]           tail_reg;
    logic [31:0]           tail_next;
    logic [31:0]           total_reg;
    logic [31:0]           total_next;
    logic [IDX_W-1:0]      oldest_reg;
    logic [IDX_W-1:0]      oldest_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      scan_reg;
    logic [CNT_W-1:0]      scan_next;
    logic [IDX_W-1:0]      rd_addr_reg;
    entry_t                rd_data_reg;
    logic [2:0]            res_status_reg;
    logic [2:0]            res_status_next;
    logic [31:0]           res_offset_reg;
    logic [31:0]           res_offset_next;

    // memory port controls
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    entry_t                mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;

    // allocation decision
    logic                  size_zero;
    logic                  too_large;
    logic                  table_full;
    logic                  table_empty;
    logic [32:0]           head_sum;
    logic                  alloc_grant;
    logic                  alloc_wrap;
    logic [2:0]            alloc_status;
    logic [31:0]           alloc_offset;
    logic [31:0]           alloc_head;
    logic [31:0]           tot_base;
    logic [33:0]           tot_sum;
    logic [31:0]           tot_sat;

    // round up to the next region boundary
    assign aligned_next = ({1'b0, size_reg} + 33'(ALIGNMENT - 1)) & ALIGN_MASK;

    assign size_zero   = (size_reg == '0);
    assign too_large   = (size_reg > {1'b0, ring_capacity[31:1]});
    assign table_full  = (count_reg >= MAX_C);
    assign table_empty = (count_reg == '0);
    assign head_sum    = {1'b0, head_reg} + aligned_reg;

    always_comb
    begin
        alloc_grant  = 1'b0;
        alloc_wrap   = 1'b0;
        alloc_status = ST_NOSPACE;
        alloc_offset = '0;
        alloc_head   = head_reg;
        priority if (size_zero)
        begin
            alloc_status = ST_ZERO;
        end
        else if (too_large)
        begin
            alloc_status = ST_LARGE;
        end
        else if (table_full)
        begin
            alloc_status = ST_FULL;
        end
        else if (table_empty)
        begin
            alloc_grant  = 1'b1;
            alloc_status = ST_GRANTED;
            alloc_head   = aligned_reg[31:0];
        end
        else if (head_reg >= tail_reg)
        begin
            if (head_sum <= {1'b0, ring_capacity})
            begin
                alloc_grant  = 1'b1;
                alloc_status = ST_GRANTED;
                alloc_offset = head_reg;
                alloc_head   = head_sum[31:0];
            end
            else if ({1'b0, tail_reg} > aligned_reg)
            begin
                // end of the ring is full, restart below tail
                alloc_grant  = 1'b1;
                alloc_wrap   = 1'b1;
                alloc_status = ST_GRANTED;
                alloc_head   = aligned_reg[31:0];
            end
        end
        else if (head_sum < {1'b0, tail_reg})
        begin
            alloc_grant  = 1'b1;
            alloc_status = ST_GRANTED;
            alloc_offset = head_reg;
            alloc_head   = head_sum[31:0];
        end
    end

    assign tot_base = table_empty ? '0 : total_reg;
    assign tot_sum  = {2'b00, tot_base} + {1'b0, aligned_reg};
    assign tot_sat  = (tot_sum[33:32] != 2'b00) ? '1 : tot_sum[31:0];

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        total_next      = total_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_addr_reg;
        mem_wdata       = rd_data_reg;

        if (cmd.load)
        begin
            scan_next = '0;
        end
        if (cmd.scan_next)
        begin
            scan_next = scan_reg + 1'b1;
        end

        if (cmd.alloc_commit)
        begin
            res_status_next = alloc_status;
            res_offset_next = alloc_offset;
            if (alloc_grant)
            begin
                head_next                    = alloc_head;
                total_next                   = tot_sat;
                count_next                   = count_reg + 1'b1;
                mem_we                       = 1'b1;
                mem_waddr                    = slot_of(oldest_reg, count_reg);
                mem_wdata.owner              = owner_reg;
                mem_wdata.start              = alloc_offset;
                mem_wdata.length             = aligned_reg[31:0];
                mem_wdata.flags              = '0;
                mem_wdata.flags[FLAG_WRAPPED] = alloc_wrap;
                if (table_empty)
                begin
                    tail_next = '0;
                end
            end
        end

        if (cmd.mark)
        begin
            mem_we                     = 1'b1;
            mem_wdata.flags[FLAG_FREED] = 1'b1;
        end

        if (cmd.retire)
        begin
            total_next  = (total_reg >= rd_data_reg.length) ?
                          (total_reg - rd_data_reg.length) : '0;
            tail_next   = rd_data_reg.flags[FLAG_WRAPPED] ? rd_data_reg.length :
                          (rd_data_reg.start + rd_data_reg.length);
            oldest_next = slot_of(oldest_reg, CNT_W'(1));
            count_next  = count_reg - 1'b1;
        end

        if (cmd.free_end)
        begin
            res_status_next = ST_FREED;
            res_offset_next = '0;
            if (table_empty)
            begin
                head_next  = '0;
                tail_next  = '0;
                total_next = '0;
            end
        end
    end

    assign mem_re    = cmd.scan_rd | cmd.ret_rd;
    assign mem_raddr = cmd.scan_rd ? slot_of(oldest_reg, scan_reg) : oldest_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            total_reg  <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            total_reg  <= total_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            scan_reg   <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            owner_reg <= in_task_id;
            size_reg  <= in_request_size;
        end
        if (cmd.latch_aligned)
        begin
            aligned_reg <= aligned_next;
        end
        if (mem_re)
        begin
            rd_addr_reg <= mem_raddr;
        end
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
    end

    assign sts.scan_more    = (scan_reg < count_reg);
    assign sts.match        = (rd_data_reg.owner == owner_reg);
    assign sts.count_zero   = table_empty;
    assign sts.oldest_freed = rd_data_reg.flags[FLAG_FREED];

    assign res_status  = res_status_reg;
    assign res_offset  = res_offset_reg;
    assign used_bytes  = total_reg;
    assign block_count = count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("block count above table depth");

    a_retire_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.retire |-> (!sts.count_zero && sts.oldest_freed))
        else $error("retire of an empty table or an unfreed block");

    a_grant_appends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit && alloc_grant) |=>
            (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("granted block not appended");

    a_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.free_end && table_empty) |=>
            (head_reg == '0 && tail_reg == '0 && total_reg == '0))
        else $error("empty table left ring pointers set");
`endif

endmodule

`default_nettype wire

### rtl/staging_ring_allocator_top.sv
// staging ring allocator top: config port, control, datapath, result register
// allocate: latch the beat, round the size up, commit the block, then emit the result beat
// free: scan held entries for the owner, mark the match freed, retire freed blocks from the oldest, then emit
// one command in flight; the next beat is taken once the result sits in the output register
// rst_n clears ring pointers, byte count, table fill and sets ring_capacity to 16777216
// table entries are not cleared; only held entries are ever read
`default_nettype none

module staging_ring_allocator_top
    import sra_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // task_id [31:0], request_size [63:32]
    input  wire logic        s_tuser,   // command [0]
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // status [2:0], offset [34:3], used_bytes [66:35],
                                        // active_blocks [71:67]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [31:0]      capacity_reg;
    logic [31:0]      capacity_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [71:0]      m_tdata_reg;
    logic             out_free;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [2:0]       res_status;
    logic [31:0]      res_offset;
    logic [31:0]      used_bytes;
    logic [CNT_W-1:0] block_count;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_RING_CAPACITY);
    assign capacity_next = cfg_write ? pwdata : capacity_reg;
    assign prdata    = (paddr[2] == REG_RING_CAPACITY) ? capacity_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    sra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .out_free   (out_free),
        .sts        (sts),
        .in_ready   (s_tready),
        .cmd        (cmd)
    );

    sra_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_task_id      (s_tdata[31:0]),
        .in_request_size (s_tdata[63:32]),
        .ring_capacity   (capacity_reg),
        .sts             (sts),
        .res_status      (res_status),
        .res_offset      (res_offset),
        .used_bytes      (used_bytes),
        .block_count     (block_count)
    );

    // result register: free once empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tdata_reg <= {5'(block_count), used_bytes, res_offset, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
